/* hw/rtl/oal_pkg.sv */
// Shared types and codes for the ordered array list engine.
// No dependencies; ordered_array_list_engine_core refers to it by scoped names.
package oal_pkg;

	// Operation selected by the kind field of an input word.
	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_FIND   = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	// Completion status reported with every result word.
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_BADPOS   = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	// Sequencer states, one-hot.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	localparam int unsigned FIELD_W = 7;
	localparam int unsigned DATA_W  = 32;
	localparam logic [FIELD_W-1:0] CAPACITY_RESET = 7'd64;

endpackage

/* hw/rtl/oal_ram.sv */
// Entry store of the list engine: one write port, one read port, registered read data.
// Depends on nothing; instantiated by ordered_array_list_engine_core.
module oal_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6,
	parameter int unsigned DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/ordered_array_list_engine_core.sv */
// Top level of the ordered array list engine: sequencer, shared compare/address unit.
// Depends on oal_pkg (types, codes) and oal_ram (entry store).
//
// Usage. A command word (kind, position, value) is taken at a rising edge where start
// is high and busy is low. Insert puts value at a 1-based position and moves the later
// entries up; delete removes and returns the entry at a position and moves the later
// entries down; find returns the 1-based position of the first equal entry; read
// returns the entry at a position. Every result word carries the list length after
// the operation. The capacity register (cfg_we, cfg_wdata) limits the number of
// entries; the limit in effect is the smaller of capacity and DEPTH. Write it only
// while the engine is idle.
//
// Timing. A command that fails its checks never raises busy; its result word appears
// with done in the next cycle. Otherwise the sequencer walks n entries through the
// single read port of the entry store, one per cycle, while busy stays high, where
// n = length-position+1 for insert and delete, 1 for read, and for find every entry on
// a miss, or on a hit the entries through the first match plus the one after it when
// there is one (at most length). No new command is taken until the walk ends. The
// result word is shown for exactly one cycle, marked by done, in the first cycle in
// which busy is low; a new command may be accepted in that same cycle. The receiver
// cannot stall the engine.
//
// Reset. arst_n clears the length to zero, the capacity to 64 and the sequencer to
// idle. The entry store itself is not cleared; only entries below the length are
// ever read, and those have all been written.
module ordered_array_list_engine_core #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           kind,
	input  logic [oal_pkg::FIELD_W-1:0]          position,
	input  logic signed [oal_pkg::DATA_W-1:0]    value,
	input  logic                                 cfg_we,
	input  logic [oal_pkg::FIELD_W-1:0]          cfg_wdata,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic signed [oal_pkg::DATA_W-1:0]    data_out,
	output logic [oal_pkg::FIELD_W-1:0]          found_position,
	output logic [oal_pkg::FIELD_W-1:0]          list_length
);

	// Address width, count width, and a width that holds every position and count
	// compare without overflow.
	localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW  = $clog2(DEPTH + 1);
	localparam int unsigned XW  = ((CW > oal_pkg::FIELD_W) ? CW : oal_pkg::FIELD_W) + 1;
	localparam int unsigned FW  = oal_pkg::FIELD_W;
	localparam int unsigned DW  = oal_pkg::DATA_W;

	oal_pkg::state_t state_q;
	oal_pkg::kind_t  kind_q;
	oal_pkg::kind_t  kind_in;

	logic [FW-1:0]    capacity_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    rem_q;
	logic [AW-1:0]    ptr_q;
	logic [AW-1:0]    pos_m1_q;
	logic [WIDTH-1:0] val_q;
	logic             hit_q;
	logic             first_q;
	logic [DW-1:0]    data_cap_q;
	logic [FW-1:0]    fpos_cap_q;

	logic             rd_vld_s1;
	logic [AW-1:0]    rd_addr_s1;

	logic             done_q;
	logic [1:0]       status_q;
	logic [DW-1:0]    data_q;
	logic [FW-1:0]    fpos_q;
	logic [FW-1:0]    len_q;

	// Command checks, all in the wide compare domain.
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cap_x;
	logic [XW-1:0] lim_x;
	logic [XW-1:0] span_x;
	logic          accept;
	logic          ins_full;
	logic          ins_badpos;
	logic          badpos;

	// Walk control.
	logic             issue;
	logic             finish;
	logic             consume;
	logic [WIDTH-1:0] rd_data;
	logic signed [WIDTH-1:0] rd_signed;
	logic signed [63:0]      rd_ext;
	logic             rd_match;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [WIDTH-1:0] wr_data;
	logic [CW-1:0]    count_next;

	assign kind_in    = oal_pkg::kind_t'(kind);
	assign accept     = start && (state_q == oal_pkg::ST_IDLE);
	assign cnt_x      = XW'(count_q);
	assign pos_x      = XW'(position);
	assign cap_x      = XW'(capacity_q);
	assign lim_x      = (cap_x < XW'(DEPTH)) ? cap_x : XW'(DEPTH);
	assign span_x     = cnt_x - pos_x + XW'(1);
	assign ins_full   = (cnt_x >= lim_x);
	assign ins_badpos = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
	assign badpos     = (pos_x == '0) || (pos_x > cnt_x);

	// One read per cycle while entries remain; find stops issuing once it has a hit.
	assign issue   = (state_q == oal_pkg::ST_WALK) && (rem_q != '0) && !hit_q;
	assign finish  = (state_q == oal_pkg::ST_WALK) && !issue && !rd_vld_s1;
	assign consume = rd_vld_s1;

	assign rd_signed = $signed(rd_data);
	assign rd_ext    = 64'(rd_signed);
	assign rd_match  = (rd_data == val_q);

	// Write port: moved entries during the walk, the new value when insert finishes.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_addr_s1 + AW'(1);
		wr_data = rd_data;
		if (consume && (kind_q == oal_pkg::KIND_INSERT)) begin
			wr_en = 1'b1;
		end else if (consume && (kind_q == oal_pkg::KIND_DELETE) && !first_q) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1 - AW'(1);
		end else if (finish && (kind_q == oal_pkg::KIND_INSERT)) begin
			wr_en   = 1'b1;
			wr_addr = pos_m1_q;
			wr_data = val_q;
		end
	end

	always_comb begin
		unique case (kind_q)
			oal_pkg::KIND_INSERT: count_next = count_q + CW'(1);
			oal_pkg::KIND_DELETE: count_next = count_q - CW'(1);
			default:              count_next = count_q;
		endcase
	end

	oal_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (issue),
		.raddr (ptr_q),
		.rdata (rd_data)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= oal_pkg::ST_IDLE;
			capacity_q <= oal_pkg::CAPACITY_RESET;
			count_q    <= '0;
			rem_q      <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			first_q    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= issue;
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			unique case (state_q)
				oal_pkg::ST_IDLE: begin
					if (accept) begin
						hit_q   <= 1'b0;
						first_q <= 1'b1;
						unique case (kind_in)
							oal_pkg::KIND_INSERT: begin
								if (ins_full || ins_badpos) begin
									done_q <= 1'b1;
								end else begin
									rem_q   <= CW'(span_x);
									state_q <= oal_pkg::ST_WALK;
								end
							end
							oal_pkg::KIND_DELETE: begin
								if (badpos) begin
									done_q <= 1'b1;
								end else begin
									rem_q   <= CW'(span_x);
									state_q <= oal_pkg::ST_WALK;
								end
							end
							oal_pkg::KIND_FIND: begin
								rem_q   <= count_q;
								state_q <= oal_pkg::ST_WALK;
							end
							oal_pkg::KIND_READ: begin
								if (badpos) begin
									done_q <= 1'b1;
								end else begin
									rem_q   <= CW'(1);
									state_q <= oal_pkg::ST_WALK;
								end
							end
						endcase
					end
				end
				oal_pkg::ST_WALK: begin
					if (issue) begin
						rem_q <= rem_q - CW'(1);
					end
					if (consume) begin
						first_q <= 1'b0;
						if ((kind_q == oal_pkg::KIND_FIND) && !hit_q && rd_match) begin
							hit_q <= 1'b1;
						end
					end
					if (finish) begin
						count_q <= count_next;
						done_q  <= 1'b1;
						state_q <= oal_pkg::ST_IDLE;
					end
				end
				default: state_q <= oal_pkg::ST_IDLE;
			endcase
		end
	end

	// Payload: walk pointer, latched command, captures and the result word.
	always_ff @(posedge clk) begin
		rd_addr_s1 <= ptr_q;
		if (issue) begin
			if (kind_q == oal_pkg::KIND_INSERT) begin
				ptr_q <= ptr_q - AW'(1);
			end else begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
		if (consume) begin
			if (first_q) begin
				data_cap_q <= rd_ext[DW-1:0];
			end
			if (!hit_q && rd_match) begin
				fpos_cap_q <= FW'(XW'(rd_addr_s1) + XW'(1));
			end
		end
		if (accept) begin
			kind_q   <= kind_in;
			val_q    <= WIDTH'($unsigned(value));
			pos_m1_q <= AW'(pos_x - XW'(1));
			unique case (kind_in)
				oal_pkg::KIND_INSERT: ptr_q <= AW'(cnt_x - XW'(1));
				oal_pkg::KIND_FIND:   ptr_q <= '0;
				default:              ptr_q <= AW'(pos_x - XW'(1));
			endcase
			// Results of commands that fail their checks are formed here.
			data_q <= '0;
			fpos_q <= '0;
			len_q  <= FW'(count_q);
			if (kind_in == oal_pkg::KIND_INSERT && ins_full) begin
				status_q <= oal_pkg::STAT_FULL;
			end else begin
				status_q <= oal_pkg::STAT_BADPOS;
			end
		end
		if (finish) begin
			len_q <= FW'(count_next);
			unique case (kind_q)
				oal_pkg::KIND_INSERT: begin
					status_q <= oal_pkg::STAT_OK;
					data_q   <= '0;
					fpos_q   <= '0;
				end
				oal_pkg::KIND_FIND: begin
					data_q <= '0;
					if (hit_q) begin
						status_q <= oal_pkg::STAT_OK;
						fpos_q   <= fpos_cap_q;
					end else begin
						status_q <= oal_pkg::STAT_NOTFOUND;
						fpos_q   <= '0;
					end
				end
				default: begin
					status_q <= oal_pkg::STAT_OK;
					data_q   <= data_cap_q;
					fpos_q   <= '0;
				end
			endcase
		end
	end

	assign busy           = (state_q != oal_pkg::ST_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign data_out       = $signed(data_q);
	assign found_position = fpos_q;
	assign list_length    = len_q;

	// An idle engine has no read in flight and writes nothing to the store.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == oal_pkg::ST_IDLE) |-> (!rd_vld_s1 && !wr_en))
		else $error("store activity while idle");

	// The length never exceeds the depth of the store.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("length beyond depth");

	// Every accepted command either starts a walk or reports at once.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command lost");

	// A failed search reports no position and no data.
	a_notfound_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == oal_pkg::STAT_NOTFOUND)) |-> (found_position == '0 && data_out == '0))
		else $error("not-found result carries data");

	// The length changes by at most one per command, and only at the end of a walk.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(finish))
		else $error("length changed outside a finishing walk");

endmodule
